// ===== hw/rtl/eslf_pkg.sv =====
// Shared types, register codes and constants for the eight-sensor line follower.
// No dependencies; every other file in this folder imports this package.
package eslf_pkg;

   localparam int unsigned MaxWheelSpeedDefault = 1000;
   localparam int unsigned MaxTurnDeltaDefault  = 500;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 23;

   localparam logic [11:0] BaseSpeedReset       = 12'd300;
   localparam logic [11:0] CorrectionSpeedReset = 12'd300;
   localparam logic [11:0] SearchSpeedReset     = 12'd200;
   localparam logic [5:0]  CenterDeadbandReset  = 6'd1;
   localparam logic [15:0] LostLimitReset       = 16'd20;
   localparam logic [22:0] InnerPercentsReset   = 23'h503214;
   localparam logic [15:0] ScoreWeightsReset    = 16'h1234;
   localparam logic [15:0] TurnGainsReset       = 16'h1020;

   // Rounded percent scaling: (speed * pct + 50) / 100, the divide done as a
   // multiply by a reciprocal that is exact for dividends up to 493000, well
   // above any sum that is not clamped first.
   localparam int unsigned PctRound     = 50;
   localparam int unsigned PctScale     = 100;
   localparam int unsigned DivInWidth   = 19;
   localparam int unsigned Div100Mult   = 335545;
   localparam int unsigned Div100Shift  = 25;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BASE_SPEED       = 3'd0,
      CSR_CORRECTION_SPEED = 3'd1,
      CSR_SEARCH_SPEED     = 3'd2,
      CSR_CENTER_DEADBAND  = 3'd3,
      CSR_LOST_LIMIT       = 3'd4,
      CSR_INNER_PERCENTS   = 3'd5,
      CSR_SCORE_WEIGHTS    = 3'd6,
      CSR_TURN_GAINS       = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_NONE  = 2'd1,
      DIR_RIGHT = 2'd2
   } dir_type;

   typedef struct packed {
      logic [11:0] base_speed;
      logic [11:0] correction_speed;
      logic [11:0] search_speed;
      logic [5:0]  center_deadband;
      logic [15:0] lost_limit;
      logic [22:0] inner_percents;
      logic [15:0] score_weights;
      logic [15:0] turn_gains;
   } cfg_type;

   typedef struct packed {
      logic [11:0]        left_base;
      logic [11:0]        right_base;
      logic               scale_en;
      logic               scale_left;
      logic [20:0]        scaled_sum;
      logic               turn_en;
      logic signed [15:0] kp_term;
      logic signed [15:0] kd_term;
      logic               clear_history;
      logic               line_seen;
   } mid_type;

endpackage

// ===== hw/rtl/eight_sensor_line_follower_core.sv =====
// Eight-sensor line follower: configuration registers and the two pipeline stages.
// A request transfer loads the input register, then the decode register is loaded and after it
// the result register, where the response is valid.
// Throughput is one transfer per cycle; each stage holds while the one after it stalls.
// Synchronous reset empties the pipeline, clears the tick state and restores register defaults.
module eight_sensor_line_follower_core
   import eslf_pkg::*;
#(
   parameter int unsigned MAX_WHEEL_SPEED = MaxWheelSpeedDefault,
   parameter int unsigned MAX_TURN_DELTA  = MaxTurnDeltaDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_sensors,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [11:0]              rsp_left_wheel,
   output logic [11:0]              rsp_right_wheel,
   output logic signed [11:0]       rsp_turn_term,
   output logic                     rsp_clear_history,
   output logic                     rsp_line_seen
);

   cfg_type cfg_ff, cfg_in;
   logic    mid_valid;
   logic    mid_ready;
   mid_type mid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_SPEED:       cfg_in.base_speed       = csr_wdata[11:0];
            CSR_CORRECTION_SPEED: cfg_in.correction_speed = csr_wdata[11:0];
            CSR_SEARCH_SPEED:     cfg_in.search_speed     = csr_wdata[11:0];
            CSR_CENTER_DEADBAND:  cfg_in.center_deadband  = csr_wdata[5:0];
            CSR_LOST_LIMIT:       cfg_in.lost_limit       = csr_wdata[15:0];
            CSR_INNER_PERCENTS:   cfg_in.inner_percents   = csr_wdata[22:0];
            CSR_SCORE_WEIGHTS:    cfg_in.score_weights    = csr_wdata[15:0];
            CSR_TURN_GAINS:       cfg_in.turn_gains       = csr_wdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed       <= BaseSpeedReset;
         cfg_ff.correction_speed <= CorrectionSpeedReset;
         cfg_ff.search_speed     <= SearchSpeedReset;
         cfg_ff.center_deadband  <= CenterDeadbandReset;
         cfg_ff.lost_limit       <= LostLimitReset;
         cfg_ff.inner_percents   <= InnerPercentsReset;
         cfg_ff.score_weights    <= ScoreWeightsReset;
         cfg_ff.turn_gains       <= TurnGainsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   eslf_control u_control (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sensors (req_sensors),
      .mid_valid   (mid_valid),
      .mid_ready   (mid_ready),
      .mid         (mid)
   );

   eslf_finish #(
      .MAX_WHEEL_SPEED (MAX_WHEEL_SPEED),
      .MAX_TURN_DELTA  (MAX_TURN_DELTA)
   ) u_finish (
      .clock             (clock),
      .reset             (reset),
      .mid_valid         (mid_valid),
      .mid_ready         (mid_ready),
      .mid               (mid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_wheel    (rsp_left_wheel),
      .rsp_right_wheel   (rsp_right_wheel),
      .rsp_turn_term     (rsp_turn_term),
      .rsp_clear_history (rsp_clear_history),
      .rsp_line_seen     (rsp_line_seen)
   );

endmodule

// ===== hw/rtl/eslf_control.sv =====
// Input register, error and level decode, steering decisions and tick state.
// Produces the partial products for the finish stage. Depends on eslf_pkg.
module eslf_control
   import eslf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_sensors,
   output logic       mid_valid,
   input  logic       mid_ready,
   output mid_type    mid
);

   logic                s0_valid_ff, s0_valid_in;
   logic [7:0]          s0_sensors_ff;
   logic                mid_valid_ff, mid_valid_in;
   mid_type             mid_ff, mid_in;
   logic signed [7:0]   lve_ff, lve_in;
   logic signed [7:0]   prev_ff, prev_in;
   logic                centred_ff, centred_in;
   logic [15:0]         lost_ticks_ff, lost_ticks_in;

   logic                mid_free;
   logic                s0_go;
   logic [6:0]          lscore, rscore;
   logic signed [7:0]   err;
   logic signed [7:0]   db_s;
   logic                in_db;
   logic [1:0]          llev, rlev, clev;
   dir_type             dir;
   logic [7:0]          pct;
   logic [19:0]         prod;
   logic signed [8:0]   diff;
   logic signed [16:0]  kp_full;
   logic signed [17:0]  kd_full;

   assign mid_free  = !mid_valid_ff || mid_ready;
   assign s0_go     = s0_valid_ff && mid_free;
   assign req_ready = !s0_valid_ff || mid_free;
   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

   always_comb begin
      lscore = 7'd0;
      rscore = 7'd0;
      for (int i = 0; i < 4; i++) begin
         if (s0_sensors_ff[i]) begin
            lscore = lscore + 7'(cfg.score_weights[4*i +: 4]);
         end
         if (s0_sensors_ff[7-i]) begin
            rscore = rscore + 7'(cfg.score_weights[4*i +: 4]);
         end
      end
      err   = $signed({1'b0, rscore}) - $signed({1'b0, lscore});
      db_s  = $signed({2'b00, cfg.center_deadband});
      in_db = (err >= -db_s) && (err <= db_s);

      if (s0_sensors_ff[0]) llev = 2'd3;
      else if (s0_sensors_ff[1]) llev = 2'd2;
      else if (s0_sensors_ff[2]) llev = 2'd1;
      else llev = 2'd0;
      if (s0_sensors_ff[7]) rlev = 2'd3;
      else if (s0_sensors_ff[6]) rlev = 2'd2;
      else if (s0_sensors_ff[5]) rlev = 2'd1;
      else rlev = 2'd0;
      clev = (llev > rlev) ? llev : rlev;

      if (llev == 2'd0 && rlev == 2'd0) dir = DIR_NONE;
      else if (llev > rlev) dir = DIR_LEFT;
      else if (rlev > llev) dir = DIR_RIGHT;
      else if (err < 0) dir = DIR_LEFT;
      else if (err > 0) dir = DIR_RIGHT;
      else if (lve_ff < 0) dir = DIR_LEFT;
      else if (lve_ff > 0) dir = DIR_RIGHT;
      else dir = DIR_NONE;

      case (clev)
         2'd3:    pct = cfg.inner_percents[7:0];
         2'd2:    pct = cfg.inner_percents[15:8];
         default: pct = {1'b0, cfg.inner_percents[22:16]};
      endcase
      prod = 20'(cfg.correction_speed) * 20'(pct);

      diff    = $signed({err[7], err}) - $signed({prev_ff[7], prev_ff});
      kp_full = err * $signed({1'b0, cfg.turn_gains[7:0]});
      kd_full = diff * $signed({1'b0, cfg.turn_gains[15:8]});
   end

   always_comb begin
      lve_in        = lve_ff;
      prev_in       = prev_ff;
      centred_in    = centred_ff;
      lost_ticks_in = lost_ticks_ff;

      mid_in               = '0;
      mid_in.scaled_sum    = 21'(prod) + 21'(PctRound);
      mid_in.kp_term       = 16'(kp_full);
      mid_in.kd_term       = 16'(kd_full);
      mid_in.scale_left    = (dir == DIR_LEFT);
      mid_in.line_seen     = (s0_sensors_ff != 8'd0);

      if (s0_sensors_ff == 8'd0) begin
         prev_in = '0;
         if (lost_ticks_ff < cfg.lost_limit) begin
            lost_ticks_in = lost_ticks_ff + 16'd1;
            if (lve_ff < 0) begin
               mid_in.right_base = cfg.search_speed;
            end else if (lve_ff > 0) begin
               mid_in.left_base = cfg.search_speed;
            end else begin
               mid_in.left_base  = cfg.search_speed;
               mid_in.right_base = cfg.search_speed;
            end
         end
      end else begin
         lost_ticks_in = '0;
         lve_in        = err;
         if (dir == DIR_NONE && in_db) begin
            mid_in.clear_history = !centred_ff;
            centred_in           = 1'b1;
            prev_in              = '0;
            mid_in.left_base     = cfg.base_speed;
            mid_in.right_base    = cfg.base_speed;
         end else begin
            centred_in        = 1'b0;
            prev_in           = in_db ? 8'sd0 : err;
            mid_in.turn_en    = !in_db;
            mid_in.scale_en   = 1'b1;
            mid_in.left_base  = cfg.correction_speed;
            mid_in.right_base = cfg.correction_speed;
         end
      end
   end

   always_comb begin
      if (req_ready) begin
         s0_valid_in = req_valid;
      end else begin
         s0_valid_in = s0_valid_ff;
      end
      if (mid_free) begin
         mid_valid_in = s0_valid_ff;
      end else begin
         mid_valid_in = mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         mid_valid_ff  <= 1'b0;
         lve_ff        <= '0;
         prev_ff       <= '0;
         centred_ff    <= 1'b0;
         lost_ticks_ff <= '0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         mid_valid_ff <= mid_valid_in;
         if (s0_go) begin
            lve_ff        <= lve_in;
            prev_ff       <= prev_in;
            centred_ff    <= centred_in;
            lost_ticks_ff <= lost_ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_sensors_ff <= req_sensors;
      end
      if (s0_go) begin
         mid_ff <= mid_in;
      end
   end

endmodule

// ===== hw/rtl/eslf_finish.sv =====
// Percent divide, wheel clamp, PD rounding and saturation, and the result register.
// Takes the partial products from eslf_control. Depends on eslf_pkg.
module eslf_finish
   import eslf_pkg::*;
#(
   parameter int unsigned MAX_WHEEL_SPEED = MaxWheelSpeedDefault,
   parameter int unsigned MAX_TURN_DELTA  = MaxTurnDeltaDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               mid_valid,
   output logic               mid_ready,
   input  mid_type            mid,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_left_wheel,
   output logic [11:0]        rsp_right_wheel,
   output logic signed [11:0] rsp_turn_term,
   output logic               rsp_clear_history,
   output logic               rsp_line_seen
);

   localparam int unsigned ScaleLimit = (MAX_WHEEL_SPEED + 1) * PctScale;
   localparam int unsigned ProdWidth  = 2 * DivInWidth;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [11:0]         left_ff, left_in;
   logic [11:0]         right_ff, right_in;
   logic signed [11:0]  turn_ff, turn_in;
   logic                clear_ff;
   logic                seen_ff;

   logic [ProdWidth-1:0] quot_full;
   logic [11:0]          scaled;
   logic [11:0]          left_clamp, right_clamp;
   logic signed [17:0]   num, quot;
   logic signed [17:0]   lim_s;

   assign mid_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      quot_full = ProdWidth'(mid.scaled_sum[DivInWidth-1:0]) *
                  ProdWidth'(Div100Mult);
      if (mid.scaled_sum >= 21'(ScaleLimit)) begin
         scaled = 12'(MAX_WHEEL_SPEED);
      end else begin
         scaled = quot_full[Div100Shift +: 12];
      end
      left_clamp  = (mid.left_base > 12'(MAX_WHEEL_SPEED)) ?
                    12'(MAX_WHEEL_SPEED) : mid.left_base;
      right_clamp = (mid.right_base > 12'(MAX_WHEEL_SPEED)) ?
                    12'(MAX_WHEEL_SPEED) : mid.right_base;
      if (mid.scale_en) begin
         left_in  = mid.scale_left ? scaled : left_clamp;
         right_in = mid.scale_left ? right_clamp : scaled;
      end else begin
         left_in  = mid.left_base;
         right_in = mid.right_base;
      end

      num   = 18'(mid.kp_term) + 18'(mid.kd_term);
      quot  = (num + (num[17] ? 18'sd15 : 18'sd0)) >>> 4;
      lim_s = $signed(18'(MAX_TURN_DELTA));
      if (!mid.turn_en) begin
         turn_in = '0;
      end else if (quot > lim_s) begin
         turn_in = 12'(lim_s);
      end else if (quot < -lim_s) begin
         turn_in = 12'(-lim_s);
      end else begin
         turn_in = 12'(quot);
      end

      if (mid_ready) begin
         rsp_valid_in = mid_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_valid && mid_ready) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         turn_ff  <= turn_in;
         clear_ff <= mid.clear_history;
         seen_ff  <= mid.line_seen;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_wheel    = left_ff;
   assign rsp_right_wheel   = right_ff;
   assign rsp_turn_term     = turn_ff;
   assign rsp_clear_history = clear_ff;
   assign rsp_line_seen     = seen_ff;

endmodule

// ===== tb/tb_eight_sensor_line_follower_core.sv =====
// Self-checking testbench for eight_sensor_line_follower_core: sensor vectors in, wheel
// commands out. Depends on eslf_pkg for register codes, directions and reset values.
// Results are checked against a tick-by-tick predictor of the wheel, turn, history and line-seen outputs.
module tb_eight_sensor_line_follower_core
   import eslf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 6;
   localparam int PhaseCount  = 12;
   localparam int PhaseItems  = 150;

   localparam logic [7:0] DirectedSensors [24] = '{
      8'h00, 8'h18, 8'h18, 8'h10, 8'h08, 8'h01, 8'h00, 8'h80,
      8'h00, 8'h81, 8'h06, 8'h60, 8'h02, 8'h40, 8'h04, 8'h20,
      8'h07, 8'hE0, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h3C};

   typedef enum {SET_RANDOM, SET_LOWEST, SET_HIGHEST} setting_mode_type;

   typedef struct {
      logic [7:0]         sensors;
      logic [11:0]        left_wheel;
      logic [11:0]        right_wheel;
      logic signed [11:0] turn_term;
      logic               clear_history;
      logic               line_seen;
   } wheel_cmd_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   csr_index_type            csr_index = CSR_BASE_SPEED;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_sensors = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [11:0]              rsp_left_wheel;
   logic [11:0]              rsp_right_wheel;
   logic signed [11:0]       rsp_turn_term;
   logic                     rsp_clear_history;
   logic                     rsp_line_seen;

   logic [7:0]     sensor_q [$];
   wheel_cmd_type  wheel_cmd_q [$];
   logic           req_taken = 1'b0;
   int             send_gap = 0;
   int             stall_left = 0;
   int             gap_pct = 0;
   int             stall_pct = 0;
   int             cycle_count = 0;
   int             error_count = 0;

   cfg_type     line_cfg;
   int          last_heading = 0;
   int          pd_prev = 0;
   logic        centred_run = 1'b0;
   int          lost_count = 0;

   eight_sensor_line_follower_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensors       (req_sensors),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_wheel    (rsp_left_wheel),
      .rsp_right_wheel   (rsp_right_wheel),
      .rsp_turn_term     (rsp_turn_term),
      .rsp_clear_history (rsp_clear_history),
      .rsp_line_seen     (rsp_line_seen)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int side_level(input logic outer, input logic mid, input logic inner);
      if (outer) return 3;
      if (mid) return 2;
      if (inner) return 1;
      return 0;
   endfunction

   function automatic wheel_cmd_type predict_tick(input logic [7:0] s);
      wheel_cmd_type cmd;
      int w [4];
      int lscore, rscore, err, db, llev, rlev, clev;
      int pct, outer, inner, num, q, max_turn, max_wheel, kp, kd;
      dir_type dir;
      cmd.sensors       = s;
      cmd.left_wheel    = '0;
      cmd.right_wheel   = '0;
      cmd.turn_term     = '0;
      cmd.clear_history = 1'b0;
      cmd.line_seen     = (s != 8'h00);
      max_turn  = int'(MaxTurnDeltaDefault);
      max_wheel = int'(MaxWheelSpeedDefault);
      db = int'(line_cfg.center_deadband);
      for (int n = 0; n < 4; n++) w[n] = int'(line_cfg.score_weights[4*n +: 4]);
      lscore = (s[0] ? w[0] : 0) + (s[1] ? w[1] : 0) + (s[2] ? w[2] : 0) + (s[3] ? w[3] : 0);
      rscore = (s[7] ? w[0] : 0) + (s[6] ? w[1] : 0) + (s[5] ? w[2] : 0) + (s[4] ? w[3] : 0);
      err  = rscore - lscore;
      llev = side_level(s[0], s[1], s[2]);
      rlev = side_level(s[7], s[6], s[5]);
      clev = (llev > rlev) ? llev : rlev;

      if (llev == 0 && rlev == 0) dir = DIR_NONE;
      else if (llev > rlev) dir = DIR_LEFT;
      else if (rlev > llev) dir = DIR_RIGHT;
      else if (err < 0) dir = DIR_LEFT;
      else if (err > 0) dir = DIR_RIGHT;
      else if (last_heading < 0) dir = DIR_LEFT;
      else if (last_heading > 0) dir = DIR_RIGHT;
      else dir = DIR_NONE;

      if (s == 8'h00) begin
         pd_prev = 0;
         if (lost_count < int'(line_cfg.lost_limit)) begin
            lost_count = (lost_count + 1) & 16'hFFFF;
            if (last_heading < 0) begin
               cmd.right_wheel = line_cfg.search_speed;
            end else if (last_heading > 0) begin
               cmd.left_wheel = line_cfg.search_speed;
            end else begin
               cmd.left_wheel  = line_cfg.search_speed;
               cmd.right_wheel = line_cfg.search_speed;
            end
         end
      end else begin
         lost_count = 0;
         if (dir == DIR_NONE && err >= -db && err <= db) begin
            if (!centred_run) begin
               cmd.clear_history = 1'b1;
               centred_run = 1'b1;
            end
            last_heading = err;
            pd_prev = 0;
            cmd.left_wheel  = line_cfg.base_speed;
            cmd.right_wheel = line_cfg.base_speed;
         end else begin
            centred_run  = 1'b0;
            last_heading = err;
            if (err >= -db && err <= db) begin
               pd_prev = 0;
            end else begin
               kp  = int'(line_cfg.turn_gains[7:0]);
               kd  = int'(line_cfg.turn_gains[15:8]);
               num = err * kp + (err - pd_prev) * kd;
               q   = num / 16;
               pd_prev = err;
               if (q > max_turn) q = max_turn;
               if (q < -max_turn) q = -max_turn;
               cmd.turn_term = q[11:0];
            end
            if (clev >= 3) pct = int'(line_cfg.inner_percents[7:0]);
            else if (clev == 2) pct = int'(line_cfg.inner_percents[15:8]);
            else pct = int'(line_cfg.inner_percents[22:16]);
            outer = int'(line_cfg.correction_speed);
            inner = (outer * pct + PctRound) / PctScale;
            if (outer > max_wheel) outer = max_wheel;
            if (inner > max_wheel) inner = max_wheel;
            if (dir == DIR_LEFT) begin
               cmd.right_wheel = outer[11:0];
               cmd.left_wheel  = inner[11:0];
            end else begin
               cmd.left_wheel  = outer[11:0];
               cmd.right_wheel = inner[11:0];
            end
         end
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want,
                                  input logic [7:0] sensors);
      if (error_count < 100) begin
         $display("%0t mismatch on %s: got %0d, expected %0d, sensors %02h",
                  $realtime, field, got, want, sensors);
      end
      error_count++;
   endtask

   task automatic check_wheel_cmd();
      wheel_cmd_type want;
      if (wheel_cmd_q.size() == 0) begin
         report_mismatch("transfer with nothing expected", int'(rsp_left_wheel), 0, 8'h00);
         return;
      end
      want = wheel_cmd_q.pop_front();
      if (rsp_left_wheel !== want.left_wheel)
         report_mismatch("left_wheel", int'(rsp_left_wheel), int'(want.left_wheel),
                         want.sensors);
      if (rsp_right_wheel !== want.right_wheel)
         report_mismatch("right_wheel", int'(rsp_right_wheel), int'(want.right_wheel),
                         want.sensors);
      if (rsp_turn_term !== want.turn_term)
         report_mismatch("turn_term", int'(rsp_turn_term), int'(want.turn_term),
                         want.sensors);
      if (rsp_clear_history !== want.clear_history)
         report_mismatch("clear_history", int'(rsp_clear_history), int'(want.clear_history),
                         want.sensors);
      if (rsp_line_seen !== want.line_seen)
         report_mismatch("line_seen", int'(rsp_line_seen), int'(want.line_seen),
                         want.sensors);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_wheel_cmd();
         if (req_valid && req_ready) wheel_cmd_q.push_back(predict_tick(req_sensors));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sensor_q.size() != 0 && $urandom_range(99, 0) < gap_pct) begin
            send_gap = $urandom_range(17, 0);
            req_valid <= 1'b0;
         end else if (sensor_q.size() != 0) begin
            req_valid   <= 1'b1;
            req_sensors <= sensor_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end

      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(99, 0) < stall_pct) begin
         stall_left = $urandom_range(17, 0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [CsrDataWidth-1:0] pick_setting(input csr_index_type idx,
                                                           input setting_mode_type mode);
      int hi;
      case (idx)
         CSR_BASE_SPEED, CSR_CORRECTION_SPEED, CSR_SEARCH_SPEED: hi = 4095;
         CSR_CENTER_DEADBAND: hi = 60;
         CSR_INNER_PERCENTS:  hi = 6579300;
         default:             hi = 65535;
      endcase
      if (mode == SET_LOWEST) return '0;
      if (mode == SET_HIGHEST) return CsrDataWidth'(hi);
      case (idx)
         CSR_BASE_SPEED, CSR_CORRECTION_SPEED, CSR_SEARCH_SPEED: begin
            if ($urandom_range(9, 0) < 7) return CsrDataWidth'($urandom_range(1200, 0));
            return CsrDataWidth'($urandom_range(hi, 0));
         end
         CSR_CENTER_DEADBAND: begin
            if ($urandom_range(9, 0) < 7) return CsrDataWidth'($urandom_range(8, 0));
            return CsrDataWidth'($urandom_range(hi, 0));
         end
         CSR_LOST_LIMIT: begin
            if ($urandom_range(9, 0) < 8) return CsrDataWidth'($urandom_range(30, 0));
            return CsrDataWidth'($urandom_range(hi, 0));
         end
         CSR_INNER_PERCENTS: begin
            if ($urandom_range(1, 0) == 0) return CsrDataWidth'($urandom_range(hi, 0));
            return {7'($urandom_range(100, 0)), 8'($urandom_range(100, 0)),
                    8'($urandom_range(100, 0))};
         end
         default: return CsrDataWidth'($urandom_range(hi, 0));
      endcase
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         CSR_BASE_SPEED:       line_cfg.base_speed       = value[11:0];
         CSR_CORRECTION_SPEED: line_cfg.correction_speed = value[11:0];
         CSR_SEARCH_SPEED:     line_cfg.search_speed     = value[11:0];
         CSR_CENTER_DEADBAND:  line_cfg.center_deadband  = value[5:0];
         CSR_LOST_LIMIT:       line_cfg.lost_limit       = value[15:0];
         CSR_INNER_PERCENTS:   line_cfg.inner_percents   = value[22:0];
         CSR_SCORE_WEIGHTS:    line_cfg.score_weights    = value[15:0];
         CSR_TURN_GAINS:       line_cfg.turn_gains       = value[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (sensor_q.size() != 0 || req_valid || wheel_cmd_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      setting_mode_type mode;
      csr_index_type idx;
      int count, kind, width, run;
      line_cfg.base_speed       = BaseSpeedReset;
      line_cfg.correction_speed = CorrectionSpeedReset;
      line_cfg.search_speed     = SearchSpeedReset;
      line_cfg.center_deadband  = CenterDeadbandReset;
      line_cfg.lost_limit       = LostLimitReset;
      line_cfg.inner_percents   = InnerPercentsReset;
      line_cfg.score_weights    = ScoreWeightsReset;
      line_cfg.turn_gains       = TurnGainsReset;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct   = 20;
      stall_pct = 20;
      foreach (DirectedSensors[i]) sensor_q.push_back(DirectedSensors[i]);
      wait_drained();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase == 0) mode = SET_HIGHEST;
         else if (phase == 1) mode = SET_LOWEST;
         else mode = SET_RANDOM;
         idx = idx.first();
         do begin
            write_csr(idx, pick_setting(idx, mode));
            idx = idx.next();
         end while (idx != idx.first());
         @(negedge clock);
         csr_write_enable <= 1'b0;

         if (phase == PhaseCount - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(2, 0))
               0: gap_pct = 0;
               1: gap_pct = 5;
               default: gap_pct = 25;
            endcase
            case ($urandom_range(2, 0))
               0: stall_pct = 0;
               1: stall_pct = 5;
               default: stall_pct = 25;
            endcase
         end

         count = 0;
         while (count < PhaseItems) begin
            kind = $urandom_range(99, 0);
            if (kind < 55) begin
               width = $urandom_range(3, 1);
               sensor_q.push_back(8'(((1 << width) - 1) << $urandom_range(8 - width, 0)));
               count++;
            end else if (kind < 70) begin
               run = $urandom_range(30, 1);
               repeat (run) sensor_q.push_back(8'h00);
               count += run;
            end else begin
               sensor_q.push_back(8'($urandom_range(255, 0)));
               count++;
            end
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
